// ===== design/tmfa_pkg.sv =====
// Shared types, codes and constants of the tachometer median-filtered average unit
`timescale 1ns / 1ps
`default_nettype none
package tmfa_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int SAMPLE_W       = 20;
  localparam int PERIOD_W       = 24;
  localparam int FREQ_DIV_W     = 28;

  localparam logic [FREQ_DIV_W-1:0] SCALED_MEGA = 28'd256000000;
  localparam logic [17:0]           LIMIT_Q8    = 18'd256000;

  localparam logic [SAMPLE_W-1:0] FREQ_MAX_RST = 20'd256000;
  localparam logic [SAMPLE_W-1:0] FREQ_MIN_RST = 20'd0;
  localparam logic [SAMPLE_W-1:0] DEV_RST      = 20'd2560;
  localparam logic [PERIOD_W-1:0] TIMEOUT_RST  = 24'd500000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_STOPPED = 2'd1;
  localparam logic [1:0] ST_NOTFULL = 2'd2;
  localparam logic [1:0] ST_HELD    = 2'd3;

  typedef enum logic [1:0] {
    OP_PIN     = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_FREQ_MAX = 2'd0,
    REG_FREQ_MIN = 2'd1,
    REG_DEV      = 2'd2,
    REG_TIMEOUT  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_FREQ_START, S_FREQ_WAIT, S_SLOT, S_COPY, S_CAND,
    S_SCAN, S_CHECK, S_SUM, S_HOLD, S_AVG_WAIT, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_PIN, CMD_DIVQ, CMD_PUSHQ, CMD_PUSHZ, CMD_SLOTRD,
    CMD_SLOTRES, CMD_CLEAR, CMD_COPYINIT, CMD_COPY, CMD_CAND, CMD_SCAN, CMD_NEXT,
    CMD_MED, CMD_SUM, CMD_HOLD, CMD_AVGRES, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] freq_max;
    logic [SAMPLE_W-1:0] freq_min;
    logic [SAMPLE_W-1:0] dev;
    logic [PERIOD_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    op_t  op;
    logic level_change;
    logic period_zero;
    logic timeout_hit;
    logic ring_full;
    logic div_done;
    logic div_busy;
    logic cnt_full;
    logic cnt_end;
    logic median_hit;
    logic hold;
    logic out_free;
  } st_t;

endpackage
`default_nettype wire

// ===== design/tacho_median_filtered_average_unit.sv =====
// Top level: tachometer median-gated moving average with config registers
// Same-level pin change, clear and timeout go straight from dispatch to the output;
//   a pin change with a period runs the 28-bit divider, one bit a cycle; a query on a
//   part-filled ring reads one slot. Query on a full ring: copy, median ranking,
//   summing, then a divide unless the average is held. One item at a time.
// Reset (rst, synchronous, high): ring reads as zero, indexes and history cleared,
//   registers to their defaults. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module tacho_median_filtered_average_unit #(
  parameter int RING_DEPTH = tmfa_pkg::RING_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // pin_level[0], elapsed_us[24:1]
  input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // average_q8[19:0], status[21:20],
                                          // sample_added[22], sample_q8[42:23],
                                          // timed_out[43], restart_timer[44]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  tmfa_pkg::cfg_t cfg;
  tmfa_pkg::st_t  st;
  tmfa_pkg::cmd_t cmd;

  // config writes are always taken; software writes only while idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq_max <= tmfa_pkg::FREQ_MAX_RST;
      cfg.freq_min <= tmfa_pkg::FREQ_MIN_RST;
      cfg.dev      <= tmfa_pkg::DEV_RST;
      cfg.timeout  <= tmfa_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tmfa_pkg::reg_idx_t'(cfg_index))
        tmfa_pkg::REG_FREQ_MAX: cfg.freq_max <= cfg_data[19:0];
        tmfa_pkg::REG_FREQ_MIN: cfg.freq_min <= cfg_data[19:0];
        tmfa_pkg::REG_DEV:      cfg.dev      <= cfg_data[19:0];
        tmfa_pkg::REG_TIMEOUT:  cfg.timeout  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  tmfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // ring, ranking, averaging and the output register
  tmfa_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_user   (s_axis_tuser),
    .in_data   (s_axis_tdata),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // an accepted transfer takes the block out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still ready after a transfer");

  // the divider never runs while the block waits for an item
  a_div_quiet_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !st.div_busy)
    else $error("divider busy while idle");
`endif
endmodule
`default_nettype wire

// ===== design/tmfa_div.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module tmfa_div #(
  parameter int DW = 28,
  parameter int VW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               busy,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int NW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [NW-1:0] cnt;
  logic [VW:0]   sh;
  logic [VW:0]   diff;

  assign sh   = {rem, quotient[DW-1]};
  assign diff = sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (!diff[VW]) begin
        rem      <= diff[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b1};
      end else begin
        rem      <= sh[VW-1:0];
        quotient <= {quotient[DW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/tmfa_dp.sv =====
// Datapath: sample ring, work copy, median scan, sums, divider and result register
`timescale 1ns / 1ps
`default_nettype none
module tmfa_dp #(
  parameter int RING_DEPTH = tmfa_pkg::RING_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    in_user,
  input  wire logic [31:0]   in_data,
  input  wire tmfa_pkg::cfg_t cfg,
  input  wire tmfa_pkg::cmd_t cmd,
  output tmfa_pkg::st_t      st,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [47:0]        out_data
);
  localparam int IW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW   = $clog2(RING_DEPTH + 1);
  localparam int SWD  = tmfa_pkg::SAMPLE_W;
  localparam int SW   = SWD + CW;
  localparam int DW   = (SW > tmfa_pkg::FREQ_DIV_W) ? SW : tmfa_pkg::FREQ_DIV_W;
  localparam int VW   = tmfa_pkg::PERIOD_W;
  localparam int HALF = RING_DEPTH / 2;

  // latched item
  tmfa_pkg::op_t      op_r;
  logic               level_r;
  logic [VW-1:0]      elapsed_r;

  // block state
  logic               last_level;
  logic [VW-1:0]      cycle_period;
  logic [SWD-1:0]     prev_avg;
  logic [IW-1:0]      wi;
  logic [CW-1:0]      fill;
  logic [RING_DEPTH-1:0] valid;
  logic [SWD-1:0]     mem [RING_DEPTH];
  logic [SWD-1:0]     rd_q;
  logic               rd_v;
  logic [IW-1:0]      rd_addr;
  logic [SWD-1:0]     rd_val;

  // query working set
  logic [SWD-1:0]     work [RING_DEPTH];
  logic [SWD-1:0]     cand;
  logic [SWD-1:0]     median;
  logic [CW-1:0]      lt_cnt;
  logic [CW-1:0]      le_cnt;
  logic [CW-1:0]      cnt;
  logic [SW-1:0]      sum;
  logic [CW-1:0]      count;

  // result being built
  logic [SWD-1:0]     res_avg;
  logic [1:0]         res_status;
  logic               res_added;
  logic [SWD-1:0]     res_sample;
  logic               res_tout;
  logic               res_restart;

  // divider
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [DW-1:0]      div_dividend;
  logic [VW-1:0]      div_divisor;
  logic [DW-1:0]      div_q;

  logic [SWD-1:0]     gated_q;
  logic [SWD-1:0]     push_val;
  logic               do_push;
  logic [SW-1:0]      limit;
  logic               hold;
  logic [SWD:0]       hi_bound;
  logic [SWD:0]       lo_test;
  logic               keep;
  logic [SWD-1:0]     x0;

  assign x0 = work[0];

  assign gated_q = ((div_q >= DW'(cfg.freq_max)) || (div_q <= DW'(cfg.freq_min))) ?
                   '0 : div_q[SWD-1:0];
  assign do_push  = (cmd == tmfa_pkg::CMD_PUSHQ) || (cmd == tmfa_pkg::CMD_PUSHZ);
  assign push_val = (cmd == tmfa_pkg::CMD_PUSHQ) ? gated_q : '0;

  assign limit    = SW'(tmfa_pkg::LIMIT_Q8) * SW'(count);
  assign hold     = sum > limit;
  assign hi_bound = {1'b0, median} + {1'b0, cfg.dev};
  assign lo_test  = {1'b0, x0} + {1'b0, cfg.dev};
  assign keep     = !({1'b0, x0} > hi_bound) && !(lo_test < {1'b0, median});

  assign rd_addr = (cmd == tmfa_pkg::CMD_SLOTRD) ? wi : cnt[IW-1:0];
  assign rd_val  = rd_v ? rd_q : '0;

  assign div_start    = (cmd == tmfa_pkg::CMD_DIVQ) || ((cmd == tmfa_pkg::CMD_HOLD) && !hold);
  assign div_dividend = (cmd == tmfa_pkg::CMD_DIVQ) ? DW'(tmfa_pkg::SCALED_MEGA) : DW'(sum);
  assign div_divisor  = (cmd == tmfa_pkg::CMD_DIVQ) ? cycle_period : VW'(count);

  tmfa_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    st.op           = op_r;
    st.level_change = level_r != last_level;
    st.period_zero  = cycle_period == '0;
    st.timeout_hit  = elapsed_r > cfg.timeout;
    st.ring_full    = fill == CW'(RING_DEPTH);
    st.div_done     = div_done;
    st.div_busy     = div_busy;
    st.cnt_full     = cnt == CW'(RING_DEPTH);
    st.cnt_end      = cnt == CW'(RING_DEPTH - 1);
    st.median_hit   = (lt_cnt <= CW'(HALF)) && (CW'(HALF) < le_cnt);
    st.hold         = hold;
    st.out_free     = !out_valid || out_ready;
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (do_push) mem[wi] <= push_val;
    rd_q <= mem[rd_addr];
    rd_v <= valid[rd_addr];
  end

  // state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      cycle_period <= '0;
      prev_avg     <= '0;
      wi           <= '0;
      fill         <= '0;
      valid        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd == tmfa_pkg::CMD_EMIT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (cmd)
        tmfa_pkg::CMD_PIN: begin
          last_level <= level_r;
          if (!level_r) cycle_period <= elapsed_r;
        end
        tmfa_pkg::CMD_PUSHQ, tmfa_pkg::CMD_PUSHZ: begin
          valid[wi] <= 1'b1;
          wi        <= (wi == IW'(RING_DEPTH - 1)) ? '0 : wi + 1'b1;
          if (fill != CW'(RING_DEPTH)) fill <= fill + 1'b1;
        end
        tmfa_pkg::CMD_CLEAR: begin
          wi   <= '0;
          fill <= '0;
        end
        tmfa_pkg::CMD_AVGRES: prev_avg <= div_q[SWD-1:0];
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd)
      tmfa_pkg::CMD_LOAD: begin
        op_r        <= tmfa_pkg::op_t'(in_user);
        level_r     <= in_data[0];
        elapsed_r   <= in_data[24:1];
        res_avg     <= '0;
        res_status  <= tmfa_pkg::ST_OK;
        res_added   <= 1'b0;
        res_sample  <= '0;
        res_tout    <= 1'b0;
        res_restart <= 1'b0;
      end
      tmfa_pkg::CMD_PIN: begin
        if (!level_r) res_restart <= 1'b1;
      end
      tmfa_pkg::CMD_PUSHQ, tmfa_pkg::CMD_PUSHZ: begin
        res_added  <= 1'b1;
        res_sample <= push_val;
        if (op_r == tmfa_pkg::OP_TIMEOUT) res_tout <= 1'b1;
      end
      tmfa_pkg::CMD_SLOTRES: begin
        res_status <= (rd_val == '0) ? tmfa_pkg::ST_STOPPED : tmfa_pkg::ST_NOTFULL;
      end
      tmfa_pkg::CMD_COPYINIT: cnt <= '0;
      tmfa_pkg::CMD_COPY: begin
        // one stray word enters first and is pushed out by the last shift
        for (int i = 0; i < RING_DEPTH - 1; i++) work[i] <= work[i+1];
        work[RING_DEPTH-1] <= rd_val;
        cnt <= cnt + 1'b1;
      end
      tmfa_pkg::CMD_CAND: begin
        cand   <= x0;
        lt_cnt <= '0;
        le_cnt <= '0;
        cnt    <= '0;
      end
      tmfa_pkg::CMD_SCAN: begin
        for (int i = 0; i < RING_DEPTH - 1; i++) work[i] <= work[i+1];
        work[RING_DEPTH-1] <= x0;
        if (x0 < cand)  lt_cnt <= lt_cnt + 1'b1;
        if (x0 <= cand) le_cnt <= le_cnt + 1'b1;
        cnt <= cnt + 1'b1;
      end
      tmfa_pkg::CMD_NEXT: begin
        for (int i = 0; i < RING_DEPTH - 1; i++) work[i] <= work[i+1];
        work[RING_DEPTH-1] <= x0;
      end
      tmfa_pkg::CMD_MED: begin
        median <= cand;
        sum    <= '0;
        count  <= '0;
        cnt    <= '0;
      end
      tmfa_pkg::CMD_SUM: begin
        for (int i = 0; i < RING_DEPTH - 1; i++) work[i] <= work[i+1];
        work[RING_DEPTH-1] <= x0;
        if (keep) begin
          sum   <= sum + SW'(x0);
          count <= count + 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
      tmfa_pkg::CMD_HOLD: begin
        if (hold) begin
          res_avg    <= prev_avg;
          res_status <= tmfa_pkg::ST_HELD;
        end
      end
      tmfa_pkg::CMD_AVGRES: begin
        res_avg    <= div_q[SWD-1:0];
        res_status <= tmfa_pkg::ST_OK;
      end
      tmfa_pkg::CMD_EMIT: begin
        out_data <= {3'b000, res_restart, res_tout, res_sample, res_added,
                     res_status, res_avg};
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/tmfa_ctrl.sv =====
// Controller: sequences one item through the datapath
`timescale 1ns / 1ps
`default_nettype none
module tmfa_ctrl (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire tmfa_pkg::st_t st,
  output tmfa_pkg::cmd_t  cmd
);
  tmfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= tmfa_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = tmfa_pkg::CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      tmfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = tmfa_pkg::CMD_LOAD;
          state_next = tmfa_pkg::S_DISPATCH;
        end
      end
      tmfa_pkg::S_DISPATCH: begin
        case (st.op)
          tmfa_pkg::OP_PIN: begin
            if (st.level_change) begin
              cmd        = tmfa_pkg::CMD_PIN;
              state_next = tmfa_pkg::S_FREQ_START;
            end else begin
              state_next = tmfa_pkg::S_EMIT;
            end
          end
          tmfa_pkg::OP_TIMEOUT: begin
            if (st.timeout_hit) cmd = tmfa_pkg::CMD_PUSHZ;
            state_next = tmfa_pkg::S_EMIT;
          end
          tmfa_pkg::OP_QUERY: begin
            if (st.ring_full) begin
              cmd        = tmfa_pkg::CMD_COPYINIT;
              state_next = tmfa_pkg::S_COPY;
            end else begin
              cmd        = tmfa_pkg::CMD_SLOTRD;
              state_next = tmfa_pkg::S_SLOT;
            end
          end
          default: begin
            cmd        = tmfa_pkg::CMD_CLEAR;
            state_next = tmfa_pkg::S_EMIT;
          end
        endcase
      end
      tmfa_pkg::S_FREQ_START: begin
        if (st.period_zero) begin
          cmd        = tmfa_pkg::CMD_PUSHZ;
          state_next = tmfa_pkg::S_EMIT;
        end else begin
          cmd        = tmfa_pkg::CMD_DIVQ;
          state_next = tmfa_pkg::S_FREQ_WAIT;
        end
      end
      tmfa_pkg::S_FREQ_WAIT: begin
        if (st.div_done) begin
          cmd        = tmfa_pkg::CMD_PUSHQ;
          state_next = tmfa_pkg::S_EMIT;
        end
      end
      tmfa_pkg::S_SLOT: begin
        cmd        = tmfa_pkg::CMD_SLOTRES;
        state_next = tmfa_pkg::S_EMIT;
      end
      tmfa_pkg::S_COPY: begin
        cmd = tmfa_pkg::CMD_COPY;
        if (st.cnt_full) state_next = tmfa_pkg::S_CAND;
      end
      tmfa_pkg::S_CAND: begin
        cmd        = tmfa_pkg::CMD_CAND;
        state_next = tmfa_pkg::S_SCAN;
      end
      tmfa_pkg::S_SCAN: begin
        cmd = tmfa_pkg::CMD_SCAN;
        if (st.cnt_end) state_next = tmfa_pkg::S_CHECK;
      end
      tmfa_pkg::S_CHECK: begin
        if (st.median_hit) begin
          cmd        = tmfa_pkg::CMD_MED;
          state_next = tmfa_pkg::S_SUM;
        end else begin
          cmd        = tmfa_pkg::CMD_NEXT;
          state_next = tmfa_pkg::S_CAND;
        end
      end
      tmfa_pkg::S_SUM: begin
        cmd = tmfa_pkg::CMD_SUM;
        if (st.cnt_end) state_next = tmfa_pkg::S_HOLD;
      end
      tmfa_pkg::S_HOLD: begin
        cmd        = tmfa_pkg::CMD_HOLD;
        state_next = st.hold ? tmfa_pkg::S_EMIT : tmfa_pkg::S_AVG_WAIT;
      end
      tmfa_pkg::S_AVG_WAIT: begin
        if (st.div_done) begin
          cmd        = tmfa_pkg::CMD_AVGRES;
          state_next = tmfa_pkg::S_EMIT;
        end
      end
      tmfa_pkg::S_EMIT: begin
        if (st.out_free) begin
          cmd        = tmfa_pkg::CMD_EMIT;
          state_next = tmfa_pkg::S_IDLE;
        end
      end
      default: state_next = tmfa_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the tachometer median-gated average unit
`timescale 1ns / 1ps
module tb;

  localparam int DEPTH = 16;

  typedef struct packed {
    tmfa_pkg::op_t op;
    logic [23:0]   elapsed;
    logic          level;
  } cmd_item_t;

  typedef struct packed {
    logic        restart_timer;
    logic        timed_out;
    logic [19:0] sample_q8;
    logic        sample_added;
    logic [1:0]  status;
    logic [19:0] average_q8;
  } tacho_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always #5 clk = ~clk;

  tacho_median_filtered_average_unit dut (.*);

  // predictor state
  logic [19:0] m_fmax, m_fmin, m_dev;
  logic [23:0] m_tout;
  logic [19:0] m_ring [DEPTH];
  int unsigned m_widx, m_fill;
  logic m_level;
  logic [23:0] m_period;
  logic [19:0] m_prev;

  cmd_item_t  pending_cmds[$];
  tacho_res_t expected_res[$];
  int failures = 0;

  function automatic logic [19:0] gate_freq(longint unsigned q);
    if (q >= m_fmax || q <= m_fmin) return '0;
    return q[19:0];
  endfunction

  function automatic logic [19:0] push_freq(longint unsigned q);
    logic [19:0] v;
    v = gate_freq(q);
    m_ring[m_widx] = v;
    m_widx = (m_widx + 1) % DEPTH;
    if (m_fill < DEPTH) m_fill++;
    return v;
  endfunction

  function automatic tacho_res_t predict_tacho(cmd_item_t c);
    tacho_res_t r;
    logic [19:0] srt [DEPTH];
    logic [19:0] key, med;
    longint unsigned q, sum, cnt;
    int j;
    r = '0;
    case (c.op)
      tmfa_pkg::OP_PIN: if (c.level != m_level) begin
        q = 0;
        if (!c.level) begin
          m_period = c.elapsed;
          r.restart_timer = 1'b1;
        end
        if (m_period != 0) q = 64'd256000000 / m_period;
        r.sample_q8 = push_freq(q);
        r.sample_added = 1'b1;
        m_level = c.level;
      end
      tmfa_pkg::OP_TIMEOUT: if (c.elapsed > m_tout) begin
        r.sample_q8 = push_freq(0);
        r.sample_added = 1'b1;
        r.timed_out = 1'b1;
      end
      tmfa_pkg::OP_QUERY: if (m_fill < DEPTH) begin
        r.status = (m_ring[m_widx] == 0) ? tmfa_pkg::ST_STOPPED : tmfa_pkg::ST_NOTFULL;
      end else begin
        srt = m_ring;
        for (int i = 1; i < DEPTH; i++) begin
          key = srt[i];
          j = i;
          while (j > 0 && srt[j-1] > key) begin
            srt[j] = srt[j-1];
            j--;
          end
          srt[j] = key;
        end
        med = srt[DEPTH/2];
        sum = 0;
        cnt = 0;
        for (int i = 0; i < DEPTH; i++) begin
          if (64'(srt[i]) > 64'(med) + m_dev) continue;
          if (64'(srt[i]) + m_dev < 64'(med)) continue;
          sum += srt[i];
          cnt++;
        end
        if (cnt == 0) cnt = 1;
        if (sum > 64'd256000 * cnt) begin
          r.average_q8 = m_prev;
          r.status = tmfa_pkg::ST_HELD;
        end else begin
          q = sum / cnt;
          r.average_q8 = q[19:0];
          r.status = tmfa_pkg::ST_OK;
        end
        m_prev = r.average_q8;
      end
      default: begin
        m_widx = 0;
        m_fill = 0;
      end
    endcase
    return r;
  endfunction

  // driver: random gap before each transfer
  int src_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_res.insert(expected_res.size(),
          predict_tacho({tmfa_pkg::op_t'(s_axis_tuser), s_axis_tdata[24:0]}));
        src_gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) src_gap = 0;
      end
      if ((!s_axis_tvalid || s_axis_tready) && src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap--;
      end else if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_cmds.size() > 0) begin
          cmd_item_t c;
          c = pending_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= c.op;
          s_axis_tdata <= {7'd0, c.elapsed, c.level};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor with random back-pressure
  int snk_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tacho_res_t got, exp_r;
        got = m_axis_tdata[44:0];
        if (expected_res.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          failures++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got.average_q8 != exp_r.average_q8) begin
            $error("average_q8 exp %0d got %0d", exp_r.average_q8, got.average_q8);
            failures++;
          end
          if (got.status != exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status);
            failures++;
          end
          if (got.sample_added != exp_r.sample_added) begin
            $error("sample_added exp %0d got %0d", exp_r.sample_added, got.sample_added);
            failures++;
          end
          if (got.sample_q8 != exp_r.sample_q8) begin
            $error("sample_q8 exp %0d got %0d", exp_r.sample_q8, got.sample_q8);
            failures++;
          end
          if (got.timed_out != exp_r.timed_out) begin
            $error("timed_out exp %0d got %0d", exp_r.timed_out, got.timed_out);
            failures++;
          end
          if (got.restart_timer != exp_r.restart_timer) begin
            $error("restart_timer exp %0d got %0d", exp_r.restart_timer,
                   got.restart_timer);
            failures++;
          end
        end
        snk_gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) snk_gap = 0;
      end
      if (snk_gap > 0) begin
        m_axis_tready <= 1'b0;
        snk_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(tmfa_pkg::reg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tmfa_pkg::REG_FREQ_MAX: m_fmax = val[19:0];
      tmfa_pkg::REG_FREQ_MIN: m_fmin = val[19:0];
      tmfa_pkg::REG_DEV:      m_dev = val[19:0];
      tmfa_pkg::REG_TIMEOUT:  m_tout = val;
      default: ;
    endcase
  endtask

  task automatic add_cmd(tmfa_pkg::op_t op, logic level, logic [23:0] el);
    cmd_item_t c;
    c.op = op;
    c.elapsed = el;
    c.level = level;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // wait until every queued command is back, then cover pending-free work
  task automatic drain_unit();
    while (pending_cmds.size() > 0 || s_axis_tvalid || expected_res.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // mostly plausible periods around a few hundred Hz, sometimes wild
  function automatic logic [23:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 24'($urandom_range(0, 300));
      1: return 24'($urandom);
      2: return 24'hFFFFFF;
      default: return 24'($urandom_range(1500, 6000));
    endcase
  endfunction

  task automatic random_phase(int n);
    logic lvl;
    lvl = m_level;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1: add_cmd(tmfa_pkg::OP_TIMEOUT, 1'($urandom), 24'($urandom));
        2, 3, 4: add_cmd(tmfa_pkg::OP_QUERY, 1'($urandom), 24'($urandom));
        5: add_cmd(tmfa_pkg::OP_CLEAR, 1'($urandom), 24'($urandom));
        6: add_cmd(tmfa_pkg::OP_PIN, lvl, pick_period());
        default: begin
          lvl = ~lvl;
          add_cmd(tmfa_pkg::OP_PIN, lvl, pick_period());
        end
      endcase
    end
    drain_unit();
  endtask

  initial begin
    m_fmax = tmfa_pkg::FREQ_MAX_RST;
    m_fmin = tmfa_pkg::FREQ_MIN_RST;
    m_dev = tmfa_pkg::DEV_RST;
    m_tout = tmfa_pkg::TIMEOUT_RST;
    for (int i = 0; i < DEPTH; i++) m_ring[i] = '0;
    m_widx = 0;
    m_fill = 0;
    m_level = 1'b0;
    m_period = '0;
    m_prev = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty ring, same level, zero period, extremes, timeouts
    add_cmd(tmfa_pkg::OP_QUERY, 1'b0, 24'd0);
    add_cmd(tmfa_pkg::OP_PIN, 1'b0, 24'd1000);
    add_cmd(tmfa_pkg::OP_PIN, 1'b1, 24'd0);
    add_cmd(tmfa_pkg::OP_PIN, 1'b0, 24'd0);
    add_cmd(tmfa_pkg::OP_PIN, 1'b1, 24'hFFFFFF);
    add_cmd(tmfa_pkg::OP_PIN, 1'b0, 24'd1);
    add_cmd(tmfa_pkg::OP_PIN, 1'b1, 24'd5);
    add_cmd(tmfa_pkg::OP_PIN, 1'b0, 24'hFFFFFF);
    add_cmd(tmfa_pkg::OP_TIMEOUT, 1'b1, 24'd500000);
    add_cmd(tmfa_pkg::OP_TIMEOUT, 1'b0, 24'd500001);
    add_cmd(tmfa_pkg::OP_QUERY, 1'b1, 24'hFFFFFF);
    for (int i = 0; i < 12; i++)
      add_cmd(tmfa_pkg::OP_PIN, i[0] ? 1'b0 : 1'b1, 24'(2000 + i));
    add_cmd(tmfa_pkg::OP_QUERY, 1'b0, 24'd0);
    add_cmd(tmfa_pkg::OP_CLEAR, 1'b1, 24'hFFFFFF);
    add_cmd(tmfa_pkg::OP_QUERY, 1'b0, 24'd0);
    drain_unit();
    random_phase(400);

    // extremes of every register
    write_reg(tmfa_pkg::REG_FREQ_MAX, 24'hFFFFFF);
    write_reg(tmfa_pkg::REG_FREQ_MIN, 24'd0);
    write_reg(tmfa_pkg::REG_DEV, 24'hFFFFFF);
    write_reg(tmfa_pkg::REG_TIMEOUT, 24'd0);
    random_phase(400);
    write_reg(tmfa_pkg::REG_FREQ_MAX, 24'd0);
    write_reg(tmfa_pkg::REG_DEV, 24'd0);
    write_reg(tmfa_pkg::REG_TIMEOUT, 24'hFFFFFF);
    random_phase(200);
    write_reg(tmfa_pkg::REG_FREQ_MAX, 24'd200000);
    write_reg(tmfa_pkg::REG_FREQ_MIN, 24'd40000);
    write_reg(tmfa_pkg::REG_DEV, 24'd5000);
    write_reg(tmfa_pkg::REG_TIMEOUT, 24'd8000000);
    random_phase(400);
    write_reg(tmfa_pkg::REG_FREQ_MAX, 24'hFFFFF);
    write_reg(tmfa_pkg::REG_FREQ_MIN, 24'hFFFFF);
    random_phase(150);
    for (int k = 0; k < 3; k++) begin
      write_reg(tmfa_pkg::REG_FREQ_MAX, 24'($urandom));
      write_reg(tmfa_pkg::REG_FREQ_MIN, 24'($urandom_range(0, 60000)));
      write_reg(tmfa_pkg::REG_DEV, 24'($urandom_range(0, 200000)));
      write_reg(tmfa_pkg::REG_TIMEOUT, 24'($urandom));
      random_phase(150);
    end
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule
